FILE: hdl/numeric_field_validator_core_assert.svh
// Assertion macros for the numeric field validator
`ifndef NUMERIC_FIELD_VALIDATOR_CORE_ASSERT_SVH
`define NUMERIC_FIELD_VALIDATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NFV_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nfv assertion failed");
`define NFV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nfv assertion failed");
`else
`define NFV_ASSERT_IMPL(lbl, ante, cons)
`define NFV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/nfv_pkg.sv
// Shared types and constants for the numeric field validator
`timescale 1ns / 1ps
package nfv_pkg;

	localparam int DEFAULT_VALUE_WIDTH = 32;
	localparam int MAX_VALUE_WIDTH     = 64;
	localparam int OUT_VALUE_WIDTH     = 32;
	localparam int CHAR_WIDTH          = 8;
	localparam int OUT_TDATA_WIDTH     = 40;
	localparam int PADDR_WIDTH         = 3;

	localparam logic [0:0] REG_REAL_MODE = 1'b0;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EXP_U = 8'h45;
	localparam logic [7:0] CH_EXP_L = 8'h65;

	typedef enum logic [2:0] {
		PH_LEAD  = 3'd0,
		PH_SIGN  = 3'd1,
		PH_DOT   = 3'd2,
		PH_INT   = 3'd3,
		PH_FRAC  = 3'd4,
		PH_EXP   = 3'd5,
		PH_EXPD  = 3'd6,
		PH_TRAIL = 3'd7
	} phase_t;

	typedef struct packed {
		logic                  vld;
		logic [CHAR_WIDTH-1:0] code;
	} beat_t;

	typedef struct packed {
		logic                       ok;
		logic [OUT_VALUE_WIDTH-1:0] value;
		logic                       sat;
	} result_t;

endpackage

FILE: hdl/nfv_in_reg.sv
// Input beat register between the slave stream and the parser
`timescale 1ns / 1ps
module nfv_in_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [nfv_pkg::CHAR_WIDTH-1:0] s_tdata,
	input  logic                          advance,
	output nfv_pkg::beat_t                beat_s1
);

	logic                           vld_s1;
	logic [nfv_pkg::CHAR_WIDTH-1:0] code_s1;

	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_s1 <= s_tdata;
		end
	end

	assign beat_s1.vld  = vld_s1;
	assign beat_s1.code = code_s1;

endmodule

FILE: hdl/nfv_parser.sv
// Per-character syntax state machine, value accumulator and result logic
`timescale 1ns / 1ps
module nfv_parser #(
	parameter int VALUE_WIDTH = nfv_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [nfv_pkg::CHAR_WIDTH-1:0] code,
	input  logic                           real_mode,
	output nfv_pkg::result_t               result
);

	`include "numeric_field_validator_core_assert.svh"

	localparam int PW = VALUE_WIDTH + 4;
	localparam logic [VALUE_WIDTH-1:0] TOP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	nfv_pkg::phase_t        phase_q, phase_d;
	logic                   neg_q, neg_d;
	logic [VALUE_WIDTH-1:0] acc_q, acc_d;
	logic                   ovf_q, ovf_d;
	logic                   err_q, err_d;

	logic                   is_ws, is_dig, is_exp, is_sgn, is_dot;
	logic                   dig_neg;
	logic [VALUE_WIDTH-1:0] limit;
	logic [PW-1:0]          prod;
	logic                   dig_ovf;
	logic [VALUE_WIDTH-1:0] dig_acc;
	logic                   add_dig;
	logic                   bad;

	logic [VALUE_WIDTH-1:0]             val_w;
	logic [nfv_pkg::MAX_VALUE_WIDTH-1:0] val_wide;

	assign is_ws  = (code != nfv_pkg::CH_NUL) && (code <= nfv_pkg::CH_SPACE);
	assign is_dig = (code >= nfv_pkg::CH_ZERO) && (code <= nfv_pkg::CH_NINE);
	assign is_exp = (code == nfv_pkg::CH_EXP_L) || (code == nfv_pkg::CH_EXP_U);
	assign is_sgn = (code == nfv_pkg::CH_PLUS) || (code == nfv_pkg::CH_MINUS);
	assign is_dot = real_mode && (code == nfv_pkg::CH_DOT);

	// sign only changes in the lead phase and never on a digit, so neg_q holds
	assign dig_neg = neg_q;
	assign limit   = dig_neg ? TOP : TOP - VALUE_WIDTH'(1);
	// acc*10 + d, compared against the clamp limit
	assign prod    = PW'({acc_q, 3'b000}) + PW'({acc_q, 1'b0})
	                 + PW'(code - nfv_pkg::CH_ZERO);
	assign dig_ovf = prod > PW'(limit);
	assign dig_acc = dig_ovf ? limit : prod[VALUE_WIDTH-1:0];

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		ovf_d   = ovf_q;
		err_d   = err_q;
		add_dig = 1'b0;
		bad     = 1'b0;
		case (phase_q)
			nfv_pkg::PH_LEAD: begin
				if (is_ws) begin
					phase_d = nfv_pkg::PH_LEAD;
				end else if (is_sgn) begin
					neg_d   = (code == nfv_pkg::CH_MINUS);
					phase_d = nfv_pkg::PH_SIGN;
				end else if (is_dot) begin
					phase_d = nfv_pkg::PH_DOT;
				end else if (is_dig) begin
					add_dig = 1'b1;
					phase_d = nfv_pkg::PH_INT;
				end else begin
					bad = 1'b1;
				end
			end
			nfv_pkg::PH_SIGN: begin
				if (is_dot) begin
					phase_d = nfv_pkg::PH_DOT;
				end else if (is_dig) begin
					add_dig = 1'b1;
					phase_d = nfv_pkg::PH_INT;
				end else begin
					bad = 1'b1;
				end
			end
			nfv_pkg::PH_DOT: begin
				if (is_dig) begin
					add_dig = 1'b1;
					phase_d = nfv_pkg::PH_INT;
				end else begin
					bad = 1'b1;
				end
			end
			nfv_pkg::PH_INT: begin
				if (is_dig) begin
					add_dig = 1'b1;
				end else if (is_ws) begin
					phase_d = nfv_pkg::PH_TRAIL;
				end else if (is_dot) begin
					phase_d = nfv_pkg::PH_FRAC;
				end else if (real_mode && is_exp) begin
					phase_d = nfv_pkg::PH_EXP;
				end else begin
					bad = 1'b1;
				end
			end
			nfv_pkg::PH_FRAC: begin
				if (is_dig) begin
					phase_d = nfv_pkg::PH_FRAC;
				end else if (is_ws) begin
					phase_d = nfv_pkg::PH_TRAIL;
				end else if (real_mode && is_exp) begin
					phase_d = nfv_pkg::PH_EXP;
				end else begin
					bad = 1'b1;
				end
			end
			nfv_pkg::PH_EXP: begin
				if (is_sgn || is_dig) begin
					phase_d = nfv_pkg::PH_EXPD;
				end else if (is_ws) begin
					phase_d = nfv_pkg::PH_TRAIL;
				end else begin
					bad = 1'b1;
				end
			end
			nfv_pkg::PH_EXPD: begin
				if (is_dig) begin
					phase_d = nfv_pkg::PH_EXPD;
				end else if (is_ws) begin
					phase_d = nfv_pkg::PH_TRAIL;
				end else begin
					bad = 1'b1;
				end
			end
			nfv_pkg::PH_TRAIL: begin
				if (!is_ws) begin
					bad = 1'b1;
				end
			end
			default: begin
				bad = 1'b1;
			end
		endcase
		if (add_dig) begin
			acc_d = dig_acc;
			if (dig_ovf) begin
				ovf_d = 1'b1;
			end
		end
		if (bad) begin
			err_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nfv_pkg::PH_LEAD;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (step) begin
			if (code == nfv_pkg::CH_NUL) begin
				phase_q <= nfv_pkg::PH_LEAD;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				err_q   <= 1'b0;
			end else if (!err_q) begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
				ovf_q   <= ovf_d;
				err_q   <= err_d;
			end
		end
	end

	assign val_w    = neg_q ? (~acc_q + VALUE_WIDTH'(1)) : acc_q;
	assign val_wide = nfv_pkg::MAX_VALUE_WIDTH'(val_w);

	always_comb begin
		result.ok    = !err_q && (phase_q >= nfv_pkg::PH_INT);
		result.value = '0;
		result.sat   = 1'b0;
		if (result.ok && !real_mode) begin
			result.value = val_wide[nfv_pkg::OUT_VALUE_WIDTH-1:0];
			result.sat   = ovf_q;
		end
	end

	`NFV_ASSERT_IMPL(a_acc_in_range, !neg_q, acc_q <= TOP - VALUE_WIDTH'(1))
	`NFV_ASSERT_IMPL(a_ovf_clamped, ovf_q, acc_q == limit)
	`NFV_ASSERT_NEXT(a_clear_on_end, step && (code == nfv_pkg::CH_NUL),
		(phase_q == nfv_pkg::PH_LEAD) && (acc_q == '0) && !err_q && !ovf_q && !neg_q)
	`NFV_ASSERT_NEXT(a_err_freezes, step && (code != nfv_pkg::CH_NUL) && err_q,
		$stable(phase_q) && $stable(acc_q) && err_q)

endmodule

FILE: hdl/numeric_field_validator_core.sv
// Top level of the numeric field validator: streams, config port, result register
//
// channel  | dir | beat contents
// s_axis   | in  | one character, 0 ends the field
// m_axis   | out | one result per field
// apb      | in  | register 0: real_mode
//
// One character per cycle unless an ending character waits on m_tready; a
// character enters the input register, is parsed from there and, if it ends
// the field, its result lands in the output register.
// Only ending characters wait on m_tready; other characters wait only behind one.
// Reset clears the parse state and real_mode; no clearing pass is needed.
`timescale 1ns / 1ps
module numeric_field_validator_core #(
	parameter int VALUE_WIDTH = nfv_pkg::DEFAULT_VALUE_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [nfv_pkg::CHAR_WIDTH-1:0]       s_tdata,  // [7:0] char_code
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] format_ok, [32:1] int_value, [33] value_saturated, [39:34] zero
	output logic [nfv_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [nfv_pkg::PADDR_WIDTH-1:0]      paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	nfv_pkg::beat_t   beat_s1;
	nfv_pkg::result_t result;
	nfv_pkg::result_t out_q;
	logic             out_vld_q;
	logic             real_mode_q;
	logic             advance;
	logic             is_end;
	logic             reg_hit;

	assign is_end  = (beat_s1.code == nfv_pkg::CH_NUL);
	assign advance = beat_s1.vld && (!is_end || !out_vld_q || m_tready);

	nfv_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.beat_s1  (beat_s1)
	);

	nfv_parser #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.code      (beat_s1.code),
		.real_mode (real_mode_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && is_end) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'b000000, out_q.sat, out_q.value, out_q.ok};

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == nfv_pkg::REG_REAL_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			real_mode_q <= pwdata[0];
		end
	end

	assign prdata = reg_hit ? {31'b0, real_mode_q} : 32'b0;

endmodule

FILE: test/numeric_field_validator_core_test.sv
// Stream and register-port testbench for the numeric field validator, with a built-in parser model
`timescale 1ns / 1ps
module numeric_field_validator_core_test;
	import nfv_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 300;
	localparam int CHARS_PER_PHASE = 500;
	localparam logic [PADDR_WIDTH-1:0] ADDR_REAL_MODE = PADDR_WIDTH'(4 * REG_REAL_MODE);

	typedef struct {
		bit           m0;
		logic [127:0] head;
		bit           m1;
		logic [127:0] tail;
		bit           known;
		result_t      res;
	} text_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [CHAR_WIDTH-1:0]      s_tdata;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [OUT_TDATA_WIDTH-1:0] m_tdata;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [PADDR_WIDTH-1:0]     paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;

	numeric_field_validator_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// parser model state
	bit          real_mode_q = 0;
	phase_t      phase_q     = PH_LEAD;
	bit          neg_q       = 0;
	logic [31:0] mag_q       = '0;
	bit          ovf_q       = 0;
	bit          err_q       = 0;

	result_t     results_due[$];
	result_t     due_r;
	result_t     pred_r;
	bit          typed_use = 0;
	result_t     typed_res;
	text_row_t   dir_rows[$];
	logic [7:0]  field_buf[$];

	int          err_cnt     = 0;
	int          cycle_cnt   = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	bit          rx_hold_req = 0;
	int          hold_left   = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[numeric_field_validator_core] ERROR");
			$finish;
		end
	end

	function automatic void add_digit(logic [7:0] c);
		logic [63:0] lim;
		logic [63:0] d;
		lim = neg_q ? 64'h8000_0000 : 64'h7FFF_FFFF;
		d = 64'(c - CH_ZERO);
		if ({32'd0, mag_q} > (lim - d) / 10) begin
			mag_q = lim[31:0];
			ovf_q = 1;
		end else begin
			mag_q = mag_q * 10 + d[31:0];
		end
	endfunction

	function automatic void parse_char(logic [7:0] c);
		bit ws, dig, ex, sg, dot, bad;
		ws  = (c != CH_NUL) && (c <= CH_SPACE);
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		ex  = (c == CH_EXP_U) || (c == CH_EXP_L);
		sg  = (c == CH_PLUS) || (c == CH_MINUS);
		dot = real_mode_q && (c == CH_DOT);
		bad = 0;
		case (phase_q)
			PH_LEAD: begin
				if (sg) begin
					neg_q = (c == CH_MINUS);
					phase_q = PH_SIGN;
				end else if (dot) phase_q = PH_DOT;
				else if (dig) begin
					add_digit(c);
					phase_q = PH_INT;
				end else bad = !ws;
			end
			PH_SIGN, PH_DOT: begin
				if (dot && phase_q == PH_SIGN) phase_q = PH_DOT;
				else if (dig) begin
					add_digit(c);
					phase_q = PH_INT;
				end else bad = 1;
			end
			PH_INT: begin
				if (dig) add_digit(c);
				else if (ws) phase_q = PH_TRAIL;
				else if (dot) phase_q = PH_FRAC;
				else if (real_mode_q && ex) phase_q = PH_EXP;
				else bad = 1;
			end
			PH_FRAC: begin
				if (ws) phase_q = PH_TRAIL;
				else if (real_mode_q && ex) phase_q = PH_EXP;
				else bad = !dig;
			end
			PH_EXP: begin
				if (sg || dig) phase_q = PH_EXPD;
				else if (ws) phase_q = PH_TRAIL;
				else bad = 1;
			end
			PH_EXPD: begin
				if (ws) phase_q = PH_TRAIL;
				else bad = !dig;
			end
			PH_TRAIL: bad = !ws;
			default: bad = 1;
		endcase
		if (bad) err_q = 1;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$error("result beat with no result pending: tdata %h", m_tdata);
					err_cnt++;
				end else begin
					due_r = results_due.pop_front();
					if (m_tdata[0] !== due_r.ok) begin
						$error("format_ok: expected %0d, got %0d", due_r.ok, m_tdata[0]);
						err_cnt++;
					end
					if (m_tdata[32:1] !== due_r.value) begin
						$error("int_value: expected %h, got %h", due_r.value, m_tdata[32:1]);
						err_cnt++;
					end
					if (m_tdata[33] !== due_r.sat) begin
						$error("value_saturated: expected %0d, got %0d", due_r.sat, m_tdata[33]);
						err_cnt++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_REAL_MODE)
				real_mode_q = pwdata[0];
			if (s_tvalid && s_tready) begin
				if (s_tdata != CH_NUL) begin
					if (!err_q) parse_char(s_tdata);
				end else begin
					pred_r.ok = !err_q && (phase_q >= PH_INT);
					pred_r.value = (pred_r.ok && !real_mode_q) ? (neg_q ? -mag_q : mag_q) : '0;
					pred_r.sat = pred_r.ok && !real_mode_q && ovf_q;
					results_due.push_back(typed_use ? typed_res : pred_r);
					phase_q = PH_LEAD;
					neg_q = 0;
					mag_q = '0;
					ovf_q = 0;
					err_q = 0;
				end
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_char(input logic [7:0] c);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = c;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_text(input logic [127:0] v);
		for (int i = 15; i >= 0; i--)
			if (v[8*i +: 8] != CH_NUL) send_char(v[8*i +: 8]);
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		typed_use = 0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input bit m);
		settle();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_REAL_MODE;
		pwdata = {31'($urandom), m};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[0] !== m) begin
			$error("real_mode: expected %0d, got %0d", m, prdata[0]);
			err_cnt++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic void add_row(bit m0, logic [127:0] head, bit m1, logic [127:0] tail,
			bit known, bit ok, logic [31:0] val, bit sat);
		text_row_t r;
		r.m0 = m0;
		r.head = head;
		r.m1 = m1;
		r.tail = tail;
		r.known = known;
		r.res.ok = ok;
		r.res.value = val;
		r.res.sat = sat;
		dir_rows.push_back(r);
	endfunction

	function automatic void push_ws(int n);
		repeat (n) field_buf.push_back(8'($urandom_range(32, 1)));
	endfunction

	function automatic void push_digits(int n);
		repeat (n) field_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
	endfunction

	// mostly well-formed fields, some with one stray byte, some pure noise
	function automatic void gen_field();
		int kind;
		bit gm;
		field_buf.delete();
		kind = $urandom_range(99);
		if (kind >= 85) begin
			repeat ($urandom_range(6)) field_buf.push_back(8'($urandom_range(255, 1)));
			return;
		end
		gm = ($urandom_range(9) == 0) ? !real_mode_q : real_mode_q;
		push_ws($urandom_range(2));
		case ($urandom_range(3))
			0: field_buf.push_back(CH_PLUS);
			1: field_buf.push_back(CH_MINUS);
			default: ;
		endcase
		if (gm && $urandom_range(4) == 0) field_buf.push_back(CH_DOT);
		push_digits(($urandom_range(7) == 0) ? $urandom_range(14, 9) : $urandom_range(6, 1));
		if (gm) begin
			if ($urandom_range(1)) begin
				field_buf.push_back(CH_DOT);
				push_digits($urandom_range(3));
			end
			if ($urandom_range(1)) begin
				field_buf.push_back($urandom_range(1) ? CH_EXP_U : CH_EXP_L);
				if ($urandom_range(1)) field_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
				push_digits($urandom_range(3));
			end
		end
		push_ws($urandom_range(2));
		if (kind >= 70)
			field_buf.insert($urandom_range(field_buf.size()), 8'($urandom_range(255, 1)));
	endfunction

	initial begin
		int sent;
		bit held, paused;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		held = 0;
		paused = 0;

		add_row(0, "", 0, "0", 1, 1, 32'd0, 0);
		add_row(0, "", 0, " +2147483647 ", 1, 1, 32'h7FFF_FFFF, 0);
		add_row(0, "", 0, "-2147483648", 1, 1, 32'h8000_0000, 0);
		add_row(0, "", 0, "2147483648", 1, 1, 32'h7FFF_FFFF, 1);
		add_row(0, "", 0, "-99999999999", 1, 1, 32'h8000_0000, 1);
		add_row(0, "", 0, "", 1, 0, 32'd0, 0);
		add_row(0, "", 0, {8'h01, 8'h20, 8'h09}, 1, 0, 32'd0, 0);
		add_row(0, "", 0, "12a3", 1, 0, 32'd0, 0);
		add_row(0, "", 0, {"7", 8'hFF}, 1, 0, 32'd0, 0);
		add_row(0, "", 0, {"1", 8'h7F}, 1, 0, 32'd0, 0);
		add_row(0, "", 0, "-", 1, 0, 32'd0, 0);
		add_row(0, "", 0, "1.5", 1, 0, 32'd0, 0);
		add_row(0, "", 0, "5 6", 1, 0, 32'd0, 0);
		add_row(0, "", 0, "  -0012  ", 0, 0, 32'd0, 0);
		add_row(1, "", 1, "1.5e+10", 1, 1, 32'd0, 0);
		add_row(1, "", 1, ".5", 1, 1, 32'd0, 0);
		add_row(1, "", 1, "1e", 1, 1, 32'd0, 0);
		add_row(1, "", 1, "-.e5", 1, 0, 32'd0, 0);
		add_row(1, "", 1, "3.  ", 1, 1, 32'd0, 0);
		add_row(1, "", 1, "1E-", 1, 1, 32'd0, 0);
		add_row(1, "", 1, ".", 1, 0, 32'd0, 0);
		add_row(1, "", 1, {"+12.34E56 ", 8'h80}, 1, 0, 32'd0, 0);
		// mode switched in the middle of a field
		add_row(0, "42", 1, ".5", 0, 0, 32'd0, 0);
		add_row(1, "-12.5", 0, "", 0, 0, 32'd0, 0);
		add_row(1, "3e", 0, "7 ", 0, 0, 32'd0, 0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 20;
		rx_idle_pct = 20;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].m0 != real_mode_q) write_mode(dir_rows[i].m0);
			send_text(dir_rows[i].head);
			if (dir_rows[i].m1 != real_mode_q) write_mode(dir_rows[i].m1);
			send_text(dir_rows[i].tail);
			@(negedge clk);
			s_tvalid = 1'b0;
			typed_use = dir_rows[i].known;
			typed_res = dir_rows[i].res;
			send_char(CH_NUL);
		end

		for (int p = 0; p < 3; p++) begin
			settle();
			tx_idle_pct = (p == 0) ? 38 : (p == 1) ? 79 : 0;
			rx_idle_pct = (p == 0) ? 79 : (p == 1) ? 38 : 0;
			write_mode((p == 2) ? bit'($urandom_range(1)) : bit'(p));
			sent = 0;
			while (sent < CHARS_PER_PHASE) begin
				if ($urandom_range(99) < 6) write_mode(bit'($urandom_range(1)));
				gen_field();
				foreach (field_buf[k]) send_char(field_buf[k]);
				send_char(CH_NUL);
				sent += field_buf.size() + 1;
				if (p == 0 && !held && sent >= 150) begin
					held = 1;
					rx_hold_req = 1;
				end
				if (p == 1 && !paused && sent >= 275) begin
					paused = 1;
					settle();
				end
			end
		end

		settle();
		if (err_cnt == 0) begin
			$display("[numeric_field_validator_core] OK");
		end else begin
			$display("[numeric_field_validator_core] ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/nfv_pkg.sv
hdl/nfv_in_reg.sv
hdl/nfv_parser.sv
hdl/numeric_field_validator_core.sv
test/numeric_field_validator_core_test.sv
